// ----- rtl/sbau_pkg.sv -----
// Shared types, codes and constants of the signed BCD arithmetic unit.
`default_nettype none

package sbau_pkg;

   // Field widths fixed by the word formats
   localparam int DIGITS_DEFAULT = 16;
   localparam int DIGIT_W        = 4;
   localparam int MAG_W          = 64;
   localparam int LEN_W          = 6;

   // Operation codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_CMP = 2'd3;

   // Ordering codes
   localparam logic [1:0] ORD_LESS    = 2'd0;
   localparam logic [1:0] ORD_EQUAL   = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;

   // Digit unit modes: multiply-accumulate, or subtract with borrow
   localparam logic ALU_MAC = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic [1:0]       opcode;
      logic             a_sign;
      logic [MAG_W-1:0] a_magnitude;
      logic             b_sign;
      logic [MAG_W-1:0] b_magnitude;
   } req_word_type;

   typedef struct packed {
      logic             result_sign;
      logic [MAG_W-1:0] result_low;
      logic [MAG_W-1:0] result_high;
      logic [LEN_W-1:0] result_length;
      logic [1:0]       ordering;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- rtl/sbau_digit_alu.sv -----
// One-digit BCD unit: x*m + y + carry, or x - y - borrow, digit and carry out.
`default_nettype none

module sbau_digit_alu (
   input  logic       mode,
   input  logic [3:0] x,
   input  logic [3:0] y,
   input  logic [3:0] m,
   input  logic [3:0] cin,
   output logic [3:0] digit,
   output logic [3:0] cout
);

   logic [7:0]  prod;
   logic [6:0]  sum;
   logic [14:0] q_full;
   logic [3:0]  quot;
   logic [6:0]  rem;
   logic [4:0]  diff;

   // multiply-accumulate path, at most 99, split by 205/2048 as reciprocal of ten
   assign prod   = {4'd0, x} * {4'd0, m};
   assign sum    = prod[6:0] + {3'd0, y} + {3'd0, cin};
   assign q_full = {8'd0, sum} * 15'd205;
   assign quot   = q_full[14:11];
   assign rem    = sum - 7'({3'd0, quot} * 7'd10);

   // subtract path, biased by ten so it never goes negative
   assign diff = 5'd10 + {1'b0, x} - {1'b0, y} - {1'b0, cin};

   always_comb begin
      case (mode)
         sbau_pkg::ALU_MAC: begin
            digit = rem[3:0];
            cout  = quot;
         end
         sbau_pkg::ALU_SUB: begin
            if (diff >= 5'd10) begin
               digit = 4'(diff - 5'd10);
               cout  = 4'd0;
            end else begin
               digit = diff[3:0];
               cout  = 4'd1;
            end
         end
         default: begin
            digit = 4'd0;
            cout  = 4'd0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/sbau_out_stage.sv -----
// Output register: holds a finished result word so the core can start the next one.
`default_nettype none

module sbau_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  sbau_pkg::rsp_word_type load_word,
   output logic                   slot_free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sbau_pkg::rsp_word_type rsp_word
);

   logic                   valid_ff, valid_in;
   sbau_pkg::rsp_word_type word_ff;

   // slot opens when empty or when the held word leaves this cycle
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

// ----- rtl/signed_bcd_arithmetic_unit.sv -----
// Signed BCD add, subtract, multiply and compare unit, digit-serial (top level).
//
// Operands are sign plus DIGITS packed BCD digits; nibbles above nine count as
// nine and digits above DIGITS-1 are ignored. All arithmetic runs through one
// BCD digit unit, one digit per cycle, with operands and result held in digit
// shift registers. Every word first passes a digit-by-digit magnitude compare
// and a setup step, after which compare finishes. Add and subtract run one
// digit add/subtract pass and then shift out the upper half. Multiply runs one
// pass per multiplier digit over all operand digits plus the row carry, then
// shifts out the upper half. The result then moves into the output register
// once it is free; a new word is then taken while the result waits there.
`default_nettype none

module signed_bcd_arithmetic_unit #(
   parameter int DIGITS = sbau_pkg::DIGITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sbau_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sbau_pkg::rsp_word_type rsp_word
);

   localparam int DW    = sbau_pkg::DIGIT_W;
   localparam int PW    = DIGITS * DW;
   localparam int RES_W = 2 * PW;
   localparam int CW    = $clog2(DIGITS + 1);
   localparam int LW    = sbau_pkg::LEN_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CMP   = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    row_ff, row_in;
   logic [LW-1:0]    k_ff, k_in;
   logic [LW-1:0]    len_ff, len_in;
   logic             nz_ff, nz_in;

   logic [PW-1:0]    a_ff, a_in;
   logic [PW-1:0]    b_ff, b_in;
   logic [PW-1:0]    p_ff, p_in;
   logic [RES_W-1:0] res_ff, res_in;
   logic [3:0]       carry_ff, carry_in;
   logic [1:0]       cmp_ff, cmp_in;
   logic [1:0]       ord_ff, ord_in;
   logic [1:0]       op_ff, op_in;
   logic             a_nz_ff, a_nz_in;
   logic             b_nz_ff, b_nz_in;
   logic             sa_ff, sa_in;
   logic             sb_ff, sb_in;
   logic             rs_ff, rs_in;
   logic             sub_ff, sub_in;
   logic             swap_ff, swap_in;

   logic [PW-1:0]    a_load, b_load;
   logic             alu_mode;
   logic [3:0]       alu_x, alu_y, alu_m, alu_cin;
   logic [3:0]       alu_d, alu_cout;
   logic             push_en;
   logic [3:0]       push_digit;
   logic             out_load, slot_free;
   logic [127:0]     res_full;
   sbau_pkg::rsp_word_type out_word;

   // saturate and trim incoming digits
   always_comb begin
      logic [3:0] a_nib;
      logic [3:0] b_nib;
      a_load = '0;
      b_load = '0;
      for (int i = 0; i < DIGITS; i++) begin
         a_nib = req_word.a_magnitude[DW*i +: DW];
         b_nib = req_word.b_magnitude[DW*i +: DW];
         a_load[DW*i +: DW] = (a_nib > 4'd9) ? 4'd9 : a_nib;
         b_load[DW*i +: DW] = (b_nib > 4'd9) ? 4'd9 : b_nib;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   sbau_digit_alu u_alu (
      .mode  (alu_mode),
      .x     (alu_x),
      .y     (alu_y),
      .m     (alu_m),
      .cin   (alu_cin),
      .digit (alu_d),
      .cout  (alu_cout)
   );

   // sequencer and digit shift registers
   always_comb begin
      logic [3:0] a0;
      logic [3:0] b0;
      logic [3:0] p0;
      logic       sa_e;
      logic       sb_e;
      logic       sbx;
      logic [1:0] ord_mag;

      a0 = a_ff[3:0];
      b0 = b_ff[3:0];
      p0 = p_ff[3:0];
      sa_e = sa_ff & a_nz_ff;
      sb_e = sb_ff & b_nz_ff;
      sbx  = sb_e ^ (op_ff == sbau_pkg::OP_SUB);
      ord_mag = cmp_ff;
      if (sa_e) begin
         if (cmp_ff == sbau_pkg::ORD_LESS) begin
            ord_mag = sbau_pkg::ORD_GREATER;
         end else if (cmp_ff == sbau_pkg::ORD_GREATER) begin
            ord_mag = sbau_pkg::ORD_LESS;
         end
      end

      state_in = state_ff;
      cnt_in   = cnt_ff;
      row_in   = row_ff;
      k_in     = k_ff;
      len_in   = len_ff;
      nz_in    = nz_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      p_in     = p_ff;
      res_in   = res_ff;
      carry_in = carry_ff;
      cmp_in   = cmp_ff;
      ord_in   = ord_ff;
      op_in    = op_ff;
      a_nz_in  = a_nz_ff;
      b_nz_in  = b_nz_ff;
      sa_in    = sa_ff;
      sb_in    = sb_ff;
      rs_in    = rs_ff;
      sub_in   = sub_ff;
      swap_in  = swap_ff;

      alu_mode   = sbau_pkg::ALU_MAC;
      alu_x      = a0;
      alu_y      = b0;
      alu_m      = 4'd1;
      alu_cin    = carry_ff;
      push_en    = 1'b0;
      push_digit = alu_d;
      out_load   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in    = a_load;
               b_in    = b_load;
               p_in    = '0;
               op_in   = req_word.opcode;
               sa_in   = req_word.a_sign;
               sb_in   = req_word.b_sign;
               cmp_in  = sbau_pkg::ORD_EQUAL;
               a_nz_in = 1'b0;
               b_nz_in = 1'b0;
               cnt_in  = '0;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // low digit first; a higher differing digit overrides
            if (a0 > b0) begin
               cmp_in = sbau_pkg::ORD_GREATER;
            end else if (a0 < b0) begin
               cmp_in = sbau_pkg::ORD_LESS;
            end
            a_nz_in = a_nz_ff | (a0 != 4'd0);
            b_nz_in = b_nz_ff | (b0 != 4'd0);
            a_in = (a_ff >> DW) | (PW'(a0) << (PW - DW));
            b_in = (b_ff >> DW) | (PW'(b0) << (PW - DW));
            if (cnt_ff == CW'(DIGITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SETUP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SETUP: begin
            if (sa_e != sb_e) begin
               ord_in = sa_e ? sbau_pkg::ORD_LESS : sbau_pkg::ORD_GREATER;
            end else begin
               ord_in = ord_mag;
            end
            cnt_in   = '0;
            row_in   = '0;
            carry_in = 4'd0;
            k_in     = '0;
            len_in   = LW'(1);
            nz_in    = 1'b0;
            sub_in   = 1'b0;
            swap_in  = 1'b0;
            case (op_ff)
               sbau_pkg::OP_ADD, sbau_pkg::OP_SUB: begin
                  if (sa_e == sbx) begin
                     rs_in = sa_e;
                  end else if (cmp_ff != sbau_pkg::ORD_LESS) begin
                     sub_in = 1'b1;
                     rs_in  = sa_e;
                  end else begin
                     sub_in  = 1'b1;
                     swap_in = 1'b1;
                     rs_in   = sbx;
                  end
                  state_in = ST_ADD;
               end
               sbau_pkg::OP_MUL: begin
                  rs_in    = sa_e ^ sb_e;
                  state_in = ST_MUL;
               end
               default: begin
                  res_in   = '0;
                  rs_in    = 1'b0;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_ADD: begin
            alu_mode = sub_ff ? sbau_pkg::ALU_SUB : sbau_pkg::ALU_MAC;
            alu_x    = swap_ff ? b0 : a0;
            alu_y    = swap_ff ? a0 : b0;
            push_en  = 1'b1;
            carry_in = alu_cout;
            a_in     = a_ff >> DW;
            b_in     = b_ff >> DW;
            if (cnt_ff == CW'(DIGITS - 1)) begin
               // carry becomes the lowest digit of the upper half
               p_in     = PW'(alu_cout);
               cnt_in   = '0;
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL: begin
            if (cnt_ff != CW'(DIGITS)) begin
               // partial row: a digit times current multiplier digit plus running sum
               alu_x    = a0;
               alu_m    = b0;
               alu_y    = p0;
               p_in     = (p_ff >> DW) | (PW'(alu_d) << (PW - DW));
               a_in     = (a_ff >> DW) | (PW'(a0) << (PW - DW));
               carry_in = alu_cout;
               cnt_in   = cnt_ff + 1'b1;
            end else begin
               // row end: retire lowest digit, row carry enters at the top
               push_en    = 1'b1;
               push_digit = p0;
               p_in       = (p_ff >> DW) | (PW'(carry_ff) << (PW - DW));
               carry_in   = 4'd0;
               b_in       = b_ff >> DW;
               cnt_in     = '0;
               if (row_ff == CW'(DIGITS - 1)) begin
                  state_in = ST_FIN;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         ST_FIN: begin
            push_en    = 1'b1;
            push_digit = p0;
            p_in       = p_ff >> DW;
            if (cnt_ff == CW'(DIGITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result digits enter at the top, low digit first; track length
      if (push_en) begin
         res_in = (res_ff >> DW) | (RES_W'(push_digit) << (RES_W - DW));
         k_in   = k_ff + 1'b1;
         if (push_digit != 4'd0) begin
            nz_in  = 1'b1;
            len_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         row_ff   <= '0;
         k_ff     <= '0;
         len_ff   <= LW'(1);
         nz_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
         k_ff     <= k_in;
         len_ff   <= len_in;
         nz_ff    <= nz_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      p_ff     <= p_in;
      res_ff   <= res_in;
      carry_ff <= carry_in;
      cmp_ff   <= cmp_in;
      ord_ff   <= ord_in;
      op_ff    <= op_in;
      a_nz_ff  <= a_nz_in;
      b_nz_ff  <= b_nz_in;
      sa_ff    <= sa_in;
      sb_ff    <= sb_in;
      rs_ff    <= rs_in;
      sub_ff   <= sub_in;
      swap_ff  <= swap_in;
   end

   // result word; a zero result is always plus
   assign res_full = 128'(res_ff);

   always_comb begin
      out_word.result_sign   = nz_ff & rs_ff;
      out_word.result_low    = res_full[63:0];
      out_word.result_high   = res_full[127:64];
      out_word.result_length = len_ff;
      out_word.ordering      = ord_ff;
   end

   sbau_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_word (out_word),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // an accepted word starts the compare pass
   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CMP))
      else $error("accepted word did not start compare pass");

   // every arithmetic result has shifted in exactly two digits per operand digit
   a_all_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && op_ff != sbau_pkg::OP_CMP) |-> (k_ff == LW'(2 * DIGITS)))
      else $error("result digit count wrong at finish");

   // larger minus smaller never leaves a borrow
   a_no_borrow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && sub_ff && cnt_ff == CW'(DIGITS - 1)) |-> (alu_cout == 4'd0))
      else $error("subtraction ended with borrow");

   // a zero result reports one digit
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !nz_ff) |-> (len_ff == LW'(1)))
      else $error("zero result with length other than one");

   // digit counter stays within the row
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DIGITS))
      else $error("digit counter out of range");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the signed BCD arithmetic unit: directed and random words.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Digits 0..32 of a BCD magnitude, digit 0 lowest
   typedef logic [32:0][3:0] digit_row_type;

   localparam int                MAG_W        = sbau_pkg::MAG_W;
   localparam int                LIMIT_CYCLES = 3_000_000;
   localparam int                RANDOM_WORDS = 1550;
   localparam logic [MAG_W-1:0]  ALL_NINES    = {16{4'h9}};
   localparam logic [MAG_W-1:0]  ALL_ONES     = {MAG_W{1'b1}};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   sbau_pkg::req_word_type req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   sbau_pkg::rsp_word_type rsp_word;

   sbau_pkg::rsp_word_type expected_words[$];
   int                     error_count = 0;
   int                     cycle_count = 0;
   bit                     idle_off = 1'b0;

   signed_bcd_arithmetic_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Digit arithmetic for prediction
   // ---------------------------------------------------------------------

   // Nibbles above nine saturate to nine
   function automatic digit_row_type unpack_digits(input logic [MAG_W-1:0] m);
      digit_row_type d;
      int i;
      d = '0;
      for (i = 0; i < 16; i++)
         d[i] = (m[4*i +: 4] > 4'd9) ? 4'd9 : m[4*i +: 4];
      return d;
   endfunction

   function automatic int mag_compare(input digit_row_type a, input digit_row_type b);
      int i;
      for (i = 15; i >= 0; i--) begin
         if (a[i] > b[i]) return 1;
         if (a[i] < b[i]) return -1;
      end
      return 0;
   endfunction

   function automatic digit_row_type add_digits(input digit_row_type a,
                                                input digit_row_type b);
      digit_row_type r;
      int i;
      int unsigned s, carry;
      r = '0;
      carry = 0;
      for (i = 0; i <= 16; i++) begin
         s = carry + a[i] + b[i];
         r[i] = 4'(s % 10);
         carry = s / 10;
      end
      return r;
   endfunction

   // a must not be below b in magnitude
   function automatic digit_row_type sub_digits(input digit_row_type a,
                                                input digit_row_type b);
      digit_row_type r;
      int i;
      int unsigned sub, borrow;
      r = '0;
      borrow = 0;
      for (i = 0; i <= 16; i++) begin
         sub = b[i] + borrow;
         if (a[i] >= sub) begin
            r[i] = 4'(a[i] - sub);
            borrow = 0;
         end else begin
            r[i] = 4'(a[i] + 10 - sub);
            borrow = 1;
         end
      end
      return r;
   endfunction

   function automatic digit_row_type mul_digits(input digit_row_type a,
                                                input digit_row_type b);
      digit_row_type r;
      int unsigned acc[33];
      int i, j;
      int unsigned s, carry;
      for (i = 0; i <= 32; i++) acc[i] = 0;
      for (i = 0; i < 16; i++)
         for (j = 0; j < 16; j++)
            acc[i+j] += a[i] * b[j];
      r = '0;
      carry = 0;
      for (i = 0; i <= 32; i++) begin
         s = acc[i] + carry;
         r[i] = 4'(s % 10);
         carry = s / 10;
      end
      return r;
   endfunction

   // Signed sum by magnitude add or subtract
   function automatic void signed_sum(input logic sa, input digit_row_type a,
                                      input logic sb, input digit_row_type b,
                                      output logic rs, output digit_row_type r);
      if (sa == sb) begin
         r = add_digits(a, b);
         rs = sa;
      end else if (mag_compare(a, b) >= 0) begin
         r = sub_digits(a, b);
         rs = sa;
      end else begin
         r = sub_digits(b, a);
         rs = sb;
      end
   endfunction

   function automatic sbau_pkg::rsp_word_type compute_result(
         input sbau_pkg::req_word_type w);
      digit_row_type da, db, dr;
      logic sa, sb, rs;
      int m, k;
      sbau_pkg::rsp_word_type o;
      da = unpack_digits(w.a_magnitude);
      db = unpack_digits(w.b_magnitude);
      // minus zero is plus zero
      sa = w.a_sign && (da != '0);
      sb = w.b_sign && (db != '0);
      if (sa != sb) begin
         o.ordering = sa ? sbau_pkg::ORD_LESS : sbau_pkg::ORD_GREATER;
      end else begin
         m = mag_compare(da, db);
         if (sa) m = -m;
         o.ordering = (m < 0) ? sbau_pkg::ORD_LESS :
                      ((m == 0) ? sbau_pkg::ORD_EQUAL : sbau_pkg::ORD_GREATER);
      end
      dr = '0;
      rs = 1'b0;
      case (w.opcode)
         sbau_pkg::OP_ADD: signed_sum(sa, da, sb, db, rs, dr);
         sbau_pkg::OP_SUB: signed_sum(sa, da, !sb, db, rs, dr);
         sbau_pkg::OP_MUL: begin
            dr = mul_digits(da, db);
            rs = sa ^ sb;
         end
         default: ;
      endcase
      o.result_length = 6'd1;
      for (k = 0; k < 32; k++)
         if (dr[k] != 4'd0) o.result_length = 6'(k + 1);
      if (dr[31:0] == '0) rs = 1'b0;
      o.result_sign = rs;
      o.result_low  = dr[15:0];
      o.result_high = dr[31:16];
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (idle_off) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(12, 50);
   endfunction

   function automatic sbau_pkg::req_word_type make_req(input logic [1:0] op,
                                             input logic sa, input logic [MAG_W-1:0] am,
                                             input logic sb, input logic [MAG_W-1:0] bm);
      sbau_pkg::req_word_type w;
      w.opcode      = op;
      w.a_sign      = sa;
      w.a_magnitude = am;
      w.b_sign      = sb;
      w.b_magnitude = bm;
      return w;
   endfunction

   function automatic logic [MAG_W-1:0] random_magnitude();
      logic [MAG_W-1:0] m;
      int kind, n, i;
      kind = $urandom_range(0, 99);
      m = '0;
      if (kind < 10) begin
         m = '0;
      end else if (kind < 25) begin
         // raw bits, nibbles above nine included
         m = {$urandom, $urandom};
      end else if (kind < 32) begin
         m = ALL_NINES;
      end else begin
         n = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 16);
         for (i = 0; i < n; i++)
            m[4*i +: 4] = 4'($urandom_range(0, 9));
      end
      return m;
   endfunction

   function automatic sbau_pkg::req_word_type random_request();
      sbau_pkg::req_word_type w;
      int pick;
      w.opcode      = 2'($urandom_range(0, 3));
      w.a_sign      = 1'($urandom_range(0, 1));
      w.b_sign      = 1'($urandom_range(0, 1));
      w.a_magnitude = random_magnitude();
      w.b_magnitude = random_magnitude();
      pick = $urandom_range(0, 9);
      // equal and near-equal magnitudes reach deep into the digit compare
      if (pick == 0) begin
         w.b_magnitude = w.a_magnitude;
      end else if (pick == 1) begin
         w.b_magnitude = w.a_magnitude;
         w.b_magnitude[3:0] = 4'($urandom_range(0, 9));
      end
      return w;
   endfunction

   // Called at a rising edge; returns at the edge that accepts the word
   task automatic send_word(input sbau_pkg::req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(negedge clock); while (req_stall !== 1'b0);
      expected_words.push_back(compute_result(w));
      @(posedge clock);
   endtask

   // Hold off the sender until every predicted word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver stall
   // ---------------------------------------------------------------------
   initial begin
      int len, r;
      logic val;
      wait (reset == 1'b0);
      forever begin
         r = $urandom_range(0, 99);
         if (idle_off || r < 50) begin
            val = 1'b0;
            len = $urandom_range(1, 8);
         end else if (r < 90) begin
            val = 1'b1;
            len = $urandom_range(1, 3);
         end else begin
            val = 1'b1;
            len = $urandom_range(10, 50);
         end
         repeat (len) begin
            @(posedge clock);
            rsp_stall <= val;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker, sampled mid-cycle
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [MAG_W-1:0] want,
                              input logic [MAG_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      sbau_pkg::rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word, actual %h", $time, rsp_word);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("result_sign", MAG_W'(want.result_sign),
                        MAG_W'(rsp_word.result_sign));
            check_field("result_low", want.result_low, rsp_word.result_low);
            check_field("result_high", want.result_high, rsp_word.result_high);
            check_field("result_length", MAG_W'(want.result_length),
                        MAG_W'(rsp_word.result_length));
            check_field("ordering", MAG_W'(want.ordering), MAG_W'(rsp_word.ordering));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, every operation, saturation and minus zero
   task automatic test_directed();
      send_word(make_req(sbau_pkg::OP_ADD, 1'b0, '0, 1'b0, '0));
      send_word(make_req(sbau_pkg::OP_ADD, 1'b0, ALL_NINES, 1'b0, ALL_NINES));
      send_word(make_req(sbau_pkg::OP_ADD, 1'b1, ALL_NINES, 1'b1, 64'h1));
      send_word(make_req(sbau_pkg::OP_ADD, 1'b1, 64'h1, 1'b0, 64'h1));
      send_word(make_req(sbau_pkg::OP_ADD, 1'b0, ALL_ONES, 1'b0, 64'h1));
      send_word(make_req(sbau_pkg::OP_SUB, 1'b1, '0, 1'b0, '0));
      send_word(make_req(sbau_pkg::OP_SUB, 1'b0, 64'h5, 1'b0, 64'h5));
      send_word(make_req(sbau_pkg::OP_SUB, 1'b0, 64'h12, 1'b0, 64'h987));
      send_word(make_req(sbau_pkg::OP_SUB, 1'b1, 64'h250, 1'b1, 64'h1000));
      send_word(make_req(sbau_pkg::OP_SUB, 1'b0, '0, 1'b0, ALL_NINES));
      send_word(make_req(sbau_pkg::OP_SUB, 1'b0, 64'h1000_0000_0000_0000, 1'b0, 64'h1));
      send_word(make_req(sbau_pkg::OP_MUL, 1'b0, ALL_NINES, 1'b0, ALL_NINES));
      send_word(make_req(sbau_pkg::OP_MUL, 1'b1, ALL_NINES, 1'b0, ALL_NINES));
      send_word(make_req(sbau_pkg::OP_MUL, 1'b1, '0, 1'b0, 64'h123));
      send_word(make_req(sbau_pkg::OP_MUL, 1'b1, 64'h7, 1'b1, 64'h8));
      send_word(make_req(sbau_pkg::OP_MUL, 1'b0, 64'hFEDC_BA98_7654_3210, 1'b0, 64'h1));
      send_word(make_req(sbau_pkg::OP_MUL, 1'b0, 64'hA, 1'b1, 64'hB0));
      send_word(make_req(sbau_pkg::OP_CMP, 1'b1, '0, 1'b0, '0));
      send_word(make_req(sbau_pkg::OP_CMP, 1'b1, 64'h5, 1'b0, 64'h3));
      send_word(make_req(sbau_pkg::OP_CMP, 1'b1, 64'h5, 1'b1, 64'h3));
      send_word(make_req(sbau_pkg::OP_CMP, 1'b0, 64'h0009, 1'b0, 64'h10));
      send_word(make_req(sbau_pkg::OP_CMP, 1'b0, ALL_NINES, 1'b0, ALL_ONES));
      send_word(make_req(sbau_pkg::OP_CMP, 1'b1, ALL_NINES, 1'b1, ALL_NINES));
   endtask

   // Sender waits for an empty pipe between bursts
   task automatic test_drain_pause();
      int i;
      for (i = 0; i < 3; i++) send_word(random_request());
      drain_results();
      send_word(make_req(sbau_pkg::OP_MUL, 1'b0, ALL_NINES, 1'b1, ALL_NINES));
      send_word(make_req(sbau_pkg::OP_SUB, 1'b1, ALL_NINES, 1'b0, ALL_NINES));
      drain_results();
   endtask

   // Random words with one stretch where neither side idles
   task automatic test_random();
      int n;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         idle_off = (n >= 700 && n < 800);
         if (n % 250 == 249 && $urandom_range(0, 1) == 1) drain_results();
         send_word(random_request());
      end
      idle_off = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_random();
      drain_results();
      // catch any stray word after the last one
      repeat (400) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
